// ===== rtl/rx_page_ring_consumer_assert.svh =====
// Assertion macros shared by the checker of the receive ring consumer.
`ifndef RX_PAGE_RING_CONSUMER_ASSERT_SVH
`define RX_PAGE_RING_CONSUMER_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define RPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/rpr_pkg.sv =====
// Types, constants and codes of the receive page ring consumer.
package rpr_pkg;

  // Sweep and frame limits
  localparam int MAX_PACKETS = 256;
  localparam int MAX_FRAME   = 1514;
  localparam int MIN_FRAME   = 60;
  localparam int HDR_BYTES   = 4;
  localparam int MAX_SPAN    = 6;

  localparam int PAGE_W = 8;
  localparam int LEN_W  = 11;
  localparam int CNT_W  = $clog2(MAX_PACKETS + 1);

  // Header status checks: ok set, crc, align and missed clear
  localparam logic [7:0] STATUS_MASK = 8'h17;
  localparam logic [7:0] STATUS_GOOD = 8'h01;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic REG_RING_START = 1'b0;
  localparam logic REG_RING_STOP  = 1'b1;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [3:0] {
    ACT_IDLE       = 4'd0,
    ACT_START      = 4'd1,
    ACT_EMPTY      = 4'd2,
    ACT_DELIVER    = 4'd3,
    ACT_DROP       = 4'd4,
    ACT_BAD_NEXT   = 4'd5,
    ACT_BAD_STATUS = 4'd6,
    ACT_BAD_SIZE   = 4'd7,
    ACT_LIMIT      = 4'd8
  } action_e;

  typedef struct packed {
    logic [PAGE_W-1:0] ring_start;
    logic [PAGE_W-1:0] ring_stop;
  } rpr_cfg_t;

  // One classified request as it waits in the queue
  typedef struct packed {
    logic              is_start;
    logic [PAGE_W-1:0] start_page;
    logic [PAGE_W-1:0] curr_page;
    logic [PAGE_W-1:0] next_page;
    logic              next_ok;
    logic              status_ok;
    logic              len_big;
    logic              len_small;
    logic [LEN_W-1:0]  len_norm;
    logic [PAGE_W-1:0] bval;
    logic              avail;
  } rpr_entry_t;

  typedef struct packed {
    logic              reinit_chip;
    logic              first_warning;
    logic [PAGE_W-1:0] boundary_value;
    logic              boundary_write;
    logic [LEN_W-1:0]  packet_length;
    logic [PAGE_W-1:0] packet_page;
  } rpr_result_t;

endpackage

// ===== rtl/rpr_regs.sv =====
// Ring start and stop registers behind the APB-style port.
module rpr_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rpr_pkg::rpr_cfg_t cfg_o
);
  import rpr_pkg::*;

  logic [PAGE_W-1:0] ring_start_q, ring_stop_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes; the low address bits are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_start_q <= PAGE_W'(76);
      ring_stop_q  <= PAGE_W'(128);
    end else if (wr_en) begin
      if (paddr[2] == REG_RING_START) begin
        ring_start_q <= pwdata[PAGE_W-1:0];
      end else begin
        ring_stop_q <= pwdata[PAGE_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RING_STOP) begin
      prdata[PAGE_W-1:0] = ring_stop_q;
    end else begin
      prdata[PAGE_W-1:0] = ring_start_q;
    end
  end

  assign cfg_o.ring_start = ring_start_q;
  assign cfg_o.ring_stop  = ring_stop_q;

endmodule

// ===== rtl/rpr_front.sv =====
// Front end: takes requests and works out every header check that needs no ring state.
module rpr_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [55:0]         s_axis_tdata,
  input  logic [0:0]          s_axis_tuser,
  input  rpr_pkg::rpr_cfg_t   cfg_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output rpr_pkg::rpr_entry_t q_entry_o
);
  import rpr_pkg::*;

  logic [PAGE_W-1:0] bnry, curr, next, status;
  logic [15:0]       count;
  logic              avail;
  logic [PAGE_W-1:0] bnry_inc;

  assign bnry   = s_axis_tdata[7:0];
  assign curr   = s_axis_tdata[15:8];
  assign next   = s_axis_tdata[23:16];
  assign status = s_axis_tdata[31:24];
  assign count  = s_axis_tdata[47:32];
  assign avail  = s_axis_tdata[48];

  assign s_axis_tready = ~q_full_i;
  assign q_push_o      = s_axis_tvalid & ~q_full_i;

  assign bnry_inc = bnry + PAGE_W'(1);

  // Classification
  always_comb begin
    q_entry_o.is_start   = (s_axis_tuser[0] == REQ_START);
    q_entry_o.start_page = (bnry_inc == cfg_i.ring_stop) ? cfg_i.ring_start : bnry_inc;
    q_entry_o.curr_page  = curr;
    q_entry_o.next_page  = next;
    q_entry_o.next_ok    = (next >= cfg_i.ring_start) && (next < cfg_i.ring_stop);
    q_entry_o.status_ok  = ((status & STATUS_MASK) == STATUS_GOOD);
    // length = count - header; too long means the count is garbled
    q_entry_o.len_big    = ({1'b0, count} > 17'(MAX_FRAME + HDR_BYTES));
    q_entry_o.len_small  = (count < 16'(MIN_FRAME + HDR_BYTES));
    q_entry_o.len_norm   = LEN_W'(count - 16'(HDR_BYTES));
    q_entry_o.bval       = (next == cfg_i.ring_start) ? (cfg_i.ring_stop - PAGE_W'(1))
                                                      : (next - PAGE_W'(1));
    q_entry_o.avail      = avail;
  end

endmodule

// ===== rtl/rpr_fifo.sv =====
// Short request queue between front and back.
module rpr_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rpr_pkg::rpr_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rpr_pkg::rpr_entry_t entry_o
);
  import rpr_pkg::*;

  rpr_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/rpr_back.sv =====
// Back end: holds the sweep state, decides the action and registers the result.
module rpr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpr_pkg::rpr_cfg_t   cfg_i,
  input  logic                q_valid_i,
  input  rpr_pkg::rpr_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,
  output logic [3:0]          m_axis_tuser
);
  import rpr_pkg::*;

  logic [PAGE_W-1:0] read_page_q, read_page_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              active_q, active_d;
  logic              warned_q, warned_d;

  logic              out_valid_q;
  action_e           act_q, act_d;
  rpr_result_t       res_q, res_d;

  logic              wrap;
  logic signed [9:0] span;
  logic [LEN_W-1:0]  span_len;
  logic              size_bad;
  logic [LEN_W-1:0]  length;

  assign q_pop_o = q_valid_i & (~out_valid_q | m_axis_tready);

  // Length estimate from the page span when the count is garbled
  always_comb begin
    wrap = (q_entry_i.next_page < read_page_q) && (q_entry_i.next_page > cfg_i.ring_start);
    if (wrap) begin
      span = $signed({2'b00, cfg_i.ring_stop}) - $signed({2'b00, read_page_q})
           + $signed({2'b00, q_entry_i.next_page}) - $signed({2'b00, cfg_i.ring_start});
    end else begin
      span = $signed({2'b00, q_entry_i.next_page}) - $signed({2'b00, read_page_q});
    end
    span_len = {span[2:0], 8'(HDR_BYTES)};
    if (span_len > LEN_W'(MAX_FRAME)) begin
      span_len = LEN_W'(MAX_FRAME);
    end
    if (q_entry_i.len_big) begin
      // a span of zero gives a runt, so it is bad as well
      size_bad = (span < 10'sd1) || (span > 10'(MAX_SPAN));
      length   = span_len;
    end else begin
      size_bad = q_entry_i.len_small;
      length   = q_entry_i.len_norm;
    end
  end

  // Decision and next sweep state
  always_comb begin
    read_page_d = read_page_q;
    count_d     = count_q;
    active_d    = active_q;
    warned_d    = warned_q;
    act_d       = ACT_IDLE;
    res_d       = '0;
    if (q_entry_i.is_start) begin
      read_page_d       = q_entry_i.start_page;
      count_d           = '0;
      active_d          = 1'b1;
      warned_d          = 1'b0;
      act_d             = ACT_START;
      res_d.packet_page = q_entry_i.start_page;
    end else if (active_q) begin
      res_d.packet_page = read_page_q;
      active_d          = 1'b0;
      if (count_q >= CNT_W'(MAX_PACKETS)) begin
        act_d = ACT_LIMIT;
      end else if (read_page_q == q_entry_i.curr_page) begin
        act_d = ACT_EMPTY;
      end else if (!q_entry_i.next_ok) begin
        act_d             = ACT_BAD_NEXT;
        res_d.reinit_chip = 1'b1;
      end else if (!q_entry_i.status_ok) begin
        act_d             = ACT_BAD_STATUS;
        res_d.reinit_chip = 1'b1;
      end else if (size_bad) begin
        act_d             = ACT_BAD_SIZE;
        res_d.reinit_chip = 1'b1;
      end else begin
        active_d             = 1'b1;
        read_page_d          = q_entry_i.next_page;
        count_d              = count_q + CNT_W'(1);
        res_d.boundary_write = 1'b1;
        res_d.boundary_value = q_entry_i.bval;
        if (q_entry_i.avail) begin
          act_d               = ACT_DELIVER;
          res_d.packet_length = length;
        end else begin
          act_d               = ACT_DROP;
          res_d.first_warning = ~warned_q;
          warned_d            = 1'b1;
        end
      end
    end
  end

  // Sweep state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_page_q <= '0;
      count_q     <= '0;
      active_q    <= 1'b0;
      warned_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        read_page_q <= read_page_d;
        count_q     <= count_d;
        active_q    <= active_d;
        warned_q    <= warned_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      act_q <= act_d;
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = act_q;
  assign m_axis_tdata  = {2'b00, res_q};

endmodule

// ===== rtl/rx_page_ring_consumer.sv =====
// Top level of the receive page ring consumer.
//
//  channel  | direction | handshake              | contents
//  s_axis   | in        | tvalid / tready        | one request: sweep start or packet step
//  m_axis   | out       | tvalid / tready        | one result per request
//  apb      | in        | psel, penable, pready  | ring_start (0x0), ring_stop (0x4)
//
// A request is taken every cycle while the queue has room; each result passes
// through the request queue and then the result register of the back end.
// The back end decides one packet a cycle, from its own ring state, when not stalled.
// Reset sets ring_start to 76 and ring_stop to 128 and ends any sweep.
// A stalled result holds in its register; requests keep entering until the
// two-entry queue is full.
module rx_page_ring_consumer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // fields from bit 0: boundary_reg[7:0], curr_page[15:8], next_page[23:16],
  // rx_status[31:24], byte_count[47:32], buffer_available[48], zero fill
  input  logic [55:0] s_axis_tdata,
  // fields from bit 0: req_type[0]
  input  logic [0:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: packet_page[7:0], packet_length[18:8], boundary_write[19],
  // boundary_value[27:20], first_warning[28], reinit_chip[29], zero fill
  output logic [31:0] m_axis_tdata,
  // fields from bit 0: action[3:0]
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rpr_pkg::*;

  rpr_cfg_t   cfg;
  rpr_entry_t push_entry, head_entry;
  logic       q_full, q_push, q_pop, q_valid;

  rpr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rpr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  rpr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  rpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_entry_i     (head_entry),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/rpr_checker.sv =====
// Port-level checks of the receive page ring consumer, bound to the top level.
`include "rx_page_ring_consumer_assert.svh"

module rpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);
  import rpr_pkg::*;

  logic is_rel, is_err, is_deliver;

  assign is_rel     = (m_axis_tuser == ACT_DELIVER) || (m_axis_tuser == ACT_DROP);
  assign is_err     = (m_axis_tuser == ACT_BAD_NEXT) || (m_axis_tuser == ACT_BAD_STATUS)
                   || (m_axis_tuser == ACT_BAD_SIZE);
  assign is_deliver = (m_axis_tuser == ACT_DELIVER);

  // a result that is held back keeps its value
  `RPR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  // the boundary is written exactly on deliver and drop
  `RPR_ASSERT(a_bnry_write, m_axis_tvalid |-> (m_axis_tdata[19] == is_rel), "boundary write on wrong action")
  // reinit is asked for exactly on the header errors
  `RPR_ASSERT(a_reinit, m_axis_tvalid |-> (m_axis_tdata[29] == is_err), "reinit on wrong action")
  // a length is given only on deliver, and then within the frame limits
  `RPR_ASSERT(a_length, m_axis_tvalid |-> (is_deliver ? (m_axis_tdata[18:8] >= 11'(MIN_FRAME) && m_axis_tdata[18:8] <= 11'(MAX_FRAME)) : (m_axis_tdata[18:8] == '0)), "bad packet length")
  // nothing is offered in the cycle after reset is released
  `RPR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "result offered out of reset")

endmodule

bind rx_page_ring_consumer rpr_checker u_rpr_checker (.*);

// ===== tb/sv/rx_page_ring_consumer_tb.sv =====
// Self-checking testbench of the receive page ring consumer.
`timescale 1ns / 100ps

module rx_page_ring_consumer_tb;
  import rpr_pkg::*;

  // One request as the stream carries it
  typedef struct packed {
    logic        req;
    logic [7:0]  bnry;
    logic [7:0]  curr;
    logic [7:0]  nxt;
    logic [7:0]  status;
    logic [15:0] count;
    logic        avail;
  } ring_req_t;

  // One result: the action code and the packed data word
  typedef struct packed {
    action_e     act;
    rpr_result_t res;
  } ring_out_t;

  // Directed row; typed rows carry their answer, the rest use the predictor
  typedef struct {
    ring_req_t   r;
    bit          typed;
    action_e     act;
    logic [7:0]  page;
    logic        reinit;
  } plan_row_t;

  localparam int unsigned N_PHASES   = 9;
  localparam int unsigned PHASE_REQS = 120;
  localparam int unsigned LONG_STEPS = MAX_PACKETS + 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [55:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the ring registers and sweep state
  logic [7:0]  cfg_start = 8'd76;
  logic [7:0]  cfg_stop  = 8'd128;
  logic [7:0]  rd_page   = '0;
  int unsigned pkt_count = 0;
  bit          in_sweep  = 1'b0;
  bit          warned    = 1'b0;

  ring_out_t   due_results[$];
  plan_row_t   plan[$];
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned act_tally[9];
  ring_out_t   want;
  rpr_result_t seen_res;
  logic [3:0]  seen_act;

  logic [7:0] phase_start[N_PHASES] = '{8'd76, 8'd0, 8'd0, 8'd255, 8'd100,
                                        8'd200, 8'd60, 8'd250, 8'd0};
  logic [7:0] phase_stop[N_PHASES]  = '{8'd128, 8'd255, 8'd1, 8'd1, 8'd100,
                                        8'd210, 8'd64, 8'd255, 8'd255};

  rx_page_ring_consumer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 23);
  end

  // Works out the answer to one request and moves the sweep state on
  function automatic ring_out_t consume_header(input ring_req_t r);
    ring_out_t o;
    logic [7:0] p;
    int length, span, pg, nx, st, sp;
    o = '{act: ACT_IDLE, res: '0};
    pg = int'(rd_page);
    nx = int'(r.nxt);
    st = int'(cfg_start);
    sp = int'(cfg_stop);
    if (r.req == REQ_START) begin
      p = r.bnry + 8'd1;
      if (p == cfg_stop) p = cfg_start;
      rd_page   = p;
      pkt_count = 0;
      in_sweep  = 1'b1;
      warned    = 1'b0;
      o.act = ACT_START;
      o.res.packet_page = p;
      return o;
    end
    if (!in_sweep) return o;
    // every early exit ends the sweep; a good packet turns it back on
    in_sweep = 1'b0;
    o.res.packet_page = rd_page;
    if (pkt_count >= MAX_PACKETS) begin
      o.act = ACT_LIMIT;
    end else if (rd_page == r.curr) begin
      o.act = ACT_EMPTY;
    end else if (!(nx >= st && nx < sp)) begin
      o.act = ACT_BAD_NEXT;
      o.res.reinit_chip = 1'b1;
    end else if ((r.status & STATUS_MASK) != STATUS_GOOD) begin
      o.act = ACT_BAD_STATUS;
      o.res.reinit_chip = 1'b1;
    end else begin
      length = int'(r.count) - HDR_BYTES;
      // garbled count: estimate from the pages the packet spans
      if (length > MAX_FRAME) begin
        if (nx < pg && nx > st) span = sp - pg + nx - st;
        else span = nx - pg;
        if (span < 0 || span > MAX_SPAN) length = 0;
        else length = (span * 256 + HDR_BYTES > MAX_FRAME) ? MAX_FRAME
                                                          : span * 256 + HDR_BYTES;
      end
      if (length < MIN_FRAME) begin
        o.act = ACT_BAD_SIZE;
        o.res.reinit_chip = 1'b1;
      end else begin
        o.res.boundary_write = 1'b1;
        o.res.boundary_value = (r.nxt == cfg_start) ? cfg_stop - 8'd1 : r.nxt - 8'd1;
        rd_page  = r.nxt;
        pkt_count++;
        in_sweep = 1'b1;
        if (r.avail) begin
          o.act = ACT_DELIVER;
          o.res.packet_length = length[LEN_W-1:0];
        end else begin
          o.act = ACT_DROP;
          o.res.first_warning = !warned;
          warned = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // Random request, biased towards sweeps that walk well-formed headers
  function automatic ring_req_t make_request(input bit long_run);
    ring_req_t r;
    int ring_w, n;
    r.req    = REQ_STEP;
    r.bnry   = 8'($urandom);
    r.curr   = 8'($urandom);
    r.nxt    = 8'($urandom);
    r.status = 8'($urandom);
    r.count  = 16'($urandom);
    r.avail  = ($urandom_range(99) < 70);
    ring_w   = int'(cfg_stop) - int'(cfg_start);
    if (!long_run && (!in_sweep ? ($urandom_range(9) != 0) : ($urandom_range(99) < 8))) begin
      r.req = REQ_START;
      if (ring_w > 0 && $urandom_range(9) < 7)
        r.bnry = 8'(int'(cfg_start) + int'($urandom_range(ring_w)) - 1);
      return r;
    end
    if ($urandom_range(99) < 8) r.curr = rd_page;
    // next page: near the read page (with wrap), anywhere in the ring, or noise
    if (ring_w > 0 && $urandom_range(99) < 85) begin
      if ($urandom_range(1) == 1) begin
        n = int'(rd_page) + int'($urandom_range(7));
        if (n >= int'(cfg_stop) && n - int'(cfg_stop) < ring_w)
          n = int'(cfg_start) + n - int'(cfg_stop);
        else if (n < int'(cfg_start) || n >= int'(cfg_stop))
          n = int'(cfg_start) + int'($urandom_range(ring_w - 1));
      end else begin
        n = int'(cfg_start) + int'($urandom_range(ring_w - 1));
      end
      r.nxt = n[7:0];
    end
    if ($urandom_range(99) < 85) r.status = (r.status & 8'hE8) | STATUS_GOOD;
    n = int'($urandom_range(99));
    if (n < 65) r.count = 16'($urandom_range(1518, 64));
    else if (n < 75) r.count = 16'($urandom_range(63));
    else if (n < 92) r.count = 16'($urandom_range(65535, 1519));
    else begin
      case ($urandom_range(3))
        0: r.count = 16'hFFFF;
        1: r.count = 16'd0;
        2: r.count = 16'd64;
        default: r.count = 16'd1519;
      endcase
    end
    // long sweep: curr page never met, status and count always good
    if (long_run) begin
      r.curr   = 8'hFF;
      r.status = (r.status & 8'hE8) | STATUS_GOOD;
      r.count  = 16'($urandom_range(1518, 64));
    end
    return r;
  endfunction

  task automatic plan_row(input logic req, input logic [7:0] bnry, input logic [7:0] curr,
                          input logic [7:0] nxt, input logic [7:0] status,
                          input logic [15:0] count, input logic avail, input bit typed,
                          input action_e act, input logic [7:0] page, input logic reinit);
    plan_row_t row;
    row.r = '{req: req, bnry: bnry, curr: curr, nxt: nxt, status: status,
              count: count, avail: avail};
    row.typed  = typed;
    row.act    = act;
    row.page   = page;
    row.reinit = reinit;
    plan.push_back(row);
  endtask

  // Sends one request and files its expected result once it is taken
  task automatic issue_request(input ring_req_t r, input bit typed, input ring_out_t typed_out);
    ring_out_t pred;
    // idle cycles, each taken at random
    while (!calm && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, r.avail, r.count, r.status, r.nxt, r.curr, r.bnry};
    s_axis_tuser  <= r.req;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = consume_header(r);
    due_results.push_back(typed ? typed_out : pred);
    sent++;
  endtask

  // Lets every outstanding result come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_RING_START) cfg_start = val;
    else cfg_stop = val;
  endtask

  task automatic note_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: mismatch in %s: expected %0d, got %0d", what, exp_v, got_v);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_res = m_axis_tdata[29:0];
      seen_act = m_axis_tuser;
      if (seen_act <= 4'd8) act_tally[seen_act]++;
      checked++;
      if (due_results.size() == 0) begin
        note_mismatch("result with nothing outstanding", 0, seen_act);
      end else begin
        want = due_results.pop_front();
        if (seen_act != want.act) note_mismatch("action", want.act, seen_act);
        if (seen_res.packet_page != want.res.packet_page)
          note_mismatch("packet_page", want.res.packet_page, seen_res.packet_page);
        if (seen_res.packet_length != want.res.packet_length)
          note_mismatch("packet_length", want.res.packet_length, seen_res.packet_length);
        if (seen_res.boundary_write != want.res.boundary_write)
          note_mismatch("boundary_write", want.res.boundary_write, seen_res.boundary_write);
        if (seen_res.boundary_value != want.res.boundary_value)
          note_mismatch("boundary_value", want.res.boundary_value, seen_res.boundary_value);
        if (seen_res.first_warning != want.res.first_warning)
          note_mismatch("first_warning", want.res.first_warning, seen_res.first_warning);
        if (seen_res.reinit_chip != want.res.reinit_chip)
          note_mismatch("reinit_chip", want.res.reinit_chip, seen_res.reinit_chip);
      end
    end
  end

  // Main sequence
  initial begin
    ring_out_t typed_out;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows with the reset ring of 76..127
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd0,   8'h01, 16'd100,   1'b1, 1, ACT_IDLE,       8'd0,  0);
    plan_row(REQ_START, 8'd127, 8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd76, 0);
    plan_row(REQ_STEP,  8'd0,   8'd76, 8'd80,  8'h01, 16'd100,   1'b1, 1, ACT_EMPTY,      8'd76, 0);
    plan_row(REQ_START, 8'd255, 8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd0,  0);
    plan_row(REQ_STEP,  8'd0,   8'd1,  8'd0,   8'h01, 16'd100,   1'b1, 1, ACT_BAD_NEXT,   8'd0,  1);
    plan_row(REQ_START, 8'd75,  8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd76, 0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd128, 8'h01, 16'd100,   1'b1, 1, ACT_BAD_NEXT,   8'd76, 1);
    plan_row(REQ_START, 8'd75,  8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd76, 0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd80,  8'h03, 16'd100,   1'b1, 1, ACT_BAD_STATUS, 8'd76, 1);
    plan_row(REQ_START, 8'd75,  8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd76, 0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd80,  8'h17, 16'd100,   1'b1, 1, ACT_BAD_STATUS, 8'd76, 1);
    plan_row(REQ_START, 8'd75,  8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd76, 0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd80,  8'h01, 16'd3,     1'b1, 1, ACT_BAD_SIZE,   8'd76, 1);
    plan_row(REQ_START, 8'd75,  8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd76, 0);
    // full-size frame, then drops with and without the warning
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd78,  8'hE9, 16'd1518,  1'b1, 0, ACT_IDLE,       8'd0,  0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd80,  8'h01, 16'd64,    1'b0, 0, ACT_IDLE,       8'd0,  0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd82,  8'h01, 16'hFFFF,  1'b0, 0, ACT_IDLE,       8'd0,  0);
    // garbled count with next page behind the read page
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd76,  8'h01, 16'd1519,  1'b1, 1, ACT_BAD_SIZE,   8'd82, 1);
    // span across the ring end, boundary wrap, clamp to a full frame
    plan_row(REQ_START, 8'd125, 8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd126, 0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd78,  8'h01, 16'd2000,  1'b1, 0, ACT_IDLE,       8'd0,  0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd76,  8'h01, 16'd64,    1'b1, 0, ACT_IDLE,       8'd0,  0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd82,  8'h01, 16'd1519,  1'b1, 0, ACT_IDLE,       8'd0,  0);
    // restart in mid-sweep, then a span one page too long
    plan_row(REQ_START, 8'd81,  8'd0,  8'd0,   8'h00, 16'd0,     1'b0, 1, ACT_START,      8'd82, 0);
    plan_row(REQ_STEP,  8'd0,   8'd0,  8'd89,  8'h01, 16'd1519,  1'b1, 1, ACT_BAD_SIZE,   8'd82, 1);

    foreach (plan[i]) begin
      typed_out = '{act: plan[i].act, res: '0};
      typed_out.res.packet_page = plan[i].page;
      typed_out.res.reinit_chip = plan[i].reinit;
      issue_request(plan[i].r, plan[i].typed, typed_out);
    end
    settle();

    // random phases over a range of ring settings
    for (int ph = 0; ph < N_PHASES - 1; ph++) begin
      write_reg(REG_RING_START, phase_start[ph]);
      write_reg(REG_RING_STOP, phase_stop[ph]);
      calm = (ph == 1);
      for (int k = 0; k < PHASE_REQS; k++) issue_request(make_request(1'b0), 1'b0, '0);
      settle();
    end

    // one sweep long enough to hit the packet limit
    calm = 1'b0;
    write_reg(REG_RING_START, phase_start[N_PHASES-1]);
    write_reg(REG_RING_STOP, phase_stop[N_PHASES-1]);
    typed_out = '0;
    issue_request('{req: REQ_START, bnry: 8'd0, curr: 8'd0, nxt: 8'd0, status: 8'd0,
                    count: 16'd0, avail: 1'b0}, 1'b0, typed_out);
    for (int k = 0; k < LONG_STEPS; k++) issue_request(make_request(1'b1), 1'b0, '0);
    settle();
    repeat (8) @(posedge clk_i);

    $display("tb: %0d requests, %0d results; %0d delivered, %0d dropped, %0d empty",
             sent, checked, act_tally[ACT_DELIVER], act_tally[ACT_DROP], act_tally[ACT_EMPTY]);
    $display("tb: %0d header errors, %0d limit stops over %0d ring settings, %0d mismatches",
             act_tally[ACT_BAD_NEXT] + act_tally[ACT_BAD_STATUS] + act_tally[ACT_BAD_SIZE],
             act_tally[ACT_LIMIT], N_PHASES + 1, mismatches);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rpr_pkg.sv
rtl/rpr_regs.sv
rtl/rpr_front.sv
rtl/rpr_fifo.sv
rtl/rpr_back.sv
rtl/rx_page_ring_consumer.sv
rtl/rpr_checker.sv
tb/sv/rx_page_ring_consumer_tb.sv
